// ----- src/sndtmr_pkg.sv -----
// Package for the sound chip timer and interrupt core: field widths, bit positions,
// command and register codes, and the item and control struct types.
// No dependencies; every other file in src uses it.
package sndtmr_pkg;

   localparam int PEND_W     = 11;
   localparam int CNT_W      = 8;
   localparam int MODE_W     = 3;
   localparam int LEVEL_W    = 3;
   localparam int LVL_MASK_W = 8;
   localparam int LVL_IDX_W  = $clog2(LVL_MASK_W);
   localparam int NUM_TIMERS = 3;
   localparam int CMD_W      = 3;
   localparam int SEL_W      = 2;
   localparam int CSR_IDX_W  = 3;

   localparam int BIT_SOFT   = 5;
   localparam int BIT_TIMER0 = 6;
   localparam int BIT_SAMPLE = 10;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK       = 3'd0,
      CMD_SOUND_SET  = 3'd1,
      CMD_SOUND_CLR  = 3'd2,
      CMD_HOST_SET   = 3'd3,
      CMD_HOST_CLR   = 3'd4,
      CMD_TIMER_WR   = 3'd5
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SOUND_EN = 3'd0,
      CSR_HOST_EN  = 3'd1,
      CSR_LEVEL0   = 3'd2,
      CSR_LEVEL1   = 3'd3,
      CSR_LEVEL2   = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [SEL_W-1:0]  timer_sel;
      logic [PEND_W-1:0] data_bits;
   } req_type;

   typedef struct packed {
      logic [PEND_W-1:0]  sound_cpu_active;
      logic [LEVEL_W-1:0] sound_cpu_level;
      logic               host_irq;
      logic [PEND_W-1:0]  sound_cpu_pending;
      logic [PEND_W-1:0]  host_pending;
   } rsp_type;

   typedef struct packed {
      logic [PEND_W-1:0]     sound_en;
      logic [PEND_W-1:0]     host_en;
      logic [LVL_MASK_W-1:0] level0;
      logic [LVL_MASK_W-1:0] level1;
      logic [LVL_MASK_W-1:0] level2;
   } cfg_type;

   typedef struct packed {
      logic advance;
      logic tick;
      logic load;
   } timer_ctl_type;

endpackage

// ----- src/sound_chip_timers_and_interrupts_core.sv -----
// Top level of the sound chip timer and interrupt core: input register, config
// registers, three timers, pending sets and the result register.
// Depends on sndtmr_pkg, sndtmr_timer and sndtmr_irq.
//
// Every accepted item (tick, pending set or clear, or timer write) yields exactly
// one result item showing the state after that item. The core takes one item per
// clock: an item sits in the input register while the timers and pending sets
// update, and the result is then registered in the output register, which drives
// rsp_valid. When the result register is held by rsp_stall the input register
// fills and req_stall rises; throughput is then set by the consumer.
// Configuration writes are always accepted (csr_ready is always high) and take
// effect for items processed afterwards.
module sound_chip_timers_and_interrupts_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  sndtmr_pkg::req_type                 req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output sndtmr_pkg::rsp_type                 rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sndtmr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sndtmr_pkg::PEND_W-1:0]       csr_wdata
);

   logic                                in_valid_ff, in_valid_in;
   sndtmr_pkg::req_type                 in_ff;
   logic                                rsp_valid_ff, rsp_valid_in;
   sndtmr_pkg::rsp_type                 rsp_ff;
   sndtmr_pkg::rsp_type                 rsp_next;
   sndtmr_pkg::cfg_type                 cfg_ff, cfg_in;
   logic                                out_ready;
   logic                                advance;
   logic [sndtmr_pkg::NUM_TIMERS-1:0]   timer_wrap;

   assign out_ready   = !rsp_valid_ff || !rsp_stall;
   assign advance     = in_valid_ff && out_ready;
   assign req_stall   = in_valid_ff && !out_ready;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;
   assign rsp_valid_in = out_ready ? in_valid_ff : rsp_valid_ff;
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (sndtmr_pkg::csr_idx_type'(csr_index))
            sndtmr_pkg::CSR_SOUND_EN: cfg_in.sound_en = csr_wdata;
            sndtmr_pkg::CSR_HOST_EN:  cfg_in.host_en  = csr_wdata;
            sndtmr_pkg::CSR_LEVEL0:   cfg_in.level0   = csr_wdata[sndtmr_pkg::LVL_MASK_W-1:0];
            sndtmr_pkg::CSR_LEVEL1:   cfg_in.level1   = csr_wdata[sndtmr_pkg::LVL_MASK_W-1:0];
            sndtmr_pkg::CSR_LEVEL2:   cfg_in.level2   = csr_wdata[sndtmr_pkg::LVL_MASK_W-1:0];
            default: ;
         endcase
      end
   end

   for (genvar t = 0; t < sndtmr_pkg::NUM_TIMERS; t++) begin : g_timer
      sndtmr_pkg::timer_ctl_type ctl;
      always_comb begin
         ctl.advance = advance;
         ctl.tick    = (sndtmr_pkg::cmd_type'(in_ff.cmd) == sndtmr_pkg::CMD_TICK);
         ctl.load    = (sndtmr_pkg::cmd_type'(in_ff.cmd) == sndtmr_pkg::CMD_TIMER_WR)
                       && (in_ff.timer_sel == sndtmr_pkg::SEL_W'(t));
      end
      sndtmr_timer u_timer (
         .clock (clock),
         .reset (reset),
         .ctl   (ctl),
         .data  (in_ff.data_bits),
         .wrap  (timer_wrap[t])
      );
   end

   sndtmr_irq u_irq (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .req        (in_ff),
      .timer_wrap (timer_wrap),
      .cfg        (cfg_ff),
      .rsp_next   (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) in_ff <= req_data;
      if (advance) rsp_ff <= rsp_next;
   end

endmodule

// ----- src/sndtmr_timer.sv -----
// One prescaled 8-bit up-counting timer with a power-of-two prescaler.
// Depends on sndtmr_pkg; instantiated once per timer by the top level.
module sndtmr_timer (
   input  logic                            clock,
   input  logic                            reset,
   input  sndtmr_pkg::timer_ctl_type       ctl,
   input  logic [sndtmr_pkg::PEND_W-1:0]   data,
   output logic                            wrap
);

   logic [sndtmr_pkg::CNT_W-1:0]  value_ff, value_in;
   logic [sndtmr_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [sndtmr_pkg::CNT_W-1:0]  prescale_ff, prescale_in;
   logic [sndtmr_pkg::MODE_W-1:0] new_mode;

   assign new_mode = data[sndtmr_pkg::CNT_W +: sndtmr_pkg::MODE_W];

   always_comb begin
      value_in    = value_ff;
      mode_in     = mode_ff;
      prescale_in = prescale_ff;
      wrap        = 1'b0;
      if (ctl.advance && ctl.tick) begin
         if (prescale_ff <= sndtmr_pkg::CNT_W'(1)) begin
            prescale_in = sndtmr_pkg::CNT_W'(1) << mode_ff;
            value_in    = value_ff + sndtmr_pkg::CNT_W'(1);
            wrap        = (value_ff == {sndtmr_pkg::CNT_W{1'b1}});
         end else begin
            prescale_in = prescale_ff - sndtmr_pkg::CNT_W'(1);
         end
      end else if (ctl.advance && ctl.load) begin
         value_in = data[sndtmr_pkg::CNT_W-1:0];
         if (new_mode != mode_ff) begin
            mode_in     = new_mode;
            prescale_in = sndtmr_pkg::CNT_W'(1) << new_mode;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff    <= '0;
         mode_ff     <= '0;
         prescale_ff <= sndtmr_pkg::CNT_W'(1);
      end else begin
         value_ff    <= value_in;
         mode_ff     <= mode_in;
         prescale_ff <= prescale_in;
      end
   end

endmodule

// ----- src/sndtmr_irq.sv -----
// Pending-interrupt sets for the sound processor and the host, plus enable masking
// and the priority level encode. Depends on sndtmr_pkg; used by the top level.
module sndtmr_irq (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  sndtmr_pkg::req_type                 req,
   input  logic [sndtmr_pkg::NUM_TIMERS-1:0]   timer_wrap,
   input  sndtmr_pkg::cfg_type                 cfg,
   output sndtmr_pkg::rsp_type                 rsp_next
);

   logic [sndtmr_pkg::PEND_W-1:0]    sound_ff, sound_in;
   logic [sndtmr_pkg::PEND_W-1:0]    host_ff, host_in;
   logic [sndtmr_pkg::PEND_W-1:0]    sound_nx, host_nx;
   logic [sndtmr_pkg::PEND_W-1:0]    wrap_bits;
   logic [sndtmr_pkg::PEND_W-1:0]    soft_bit;
   logic [sndtmr_pkg::PEND_W-1:0]    sample_bit;
   logic [sndtmr_pkg::PEND_W-1:0]    active;
   logic [sndtmr_pkg::LEVEL_W-1:0]   level;
   logic [sndtmr_pkg::LVL_IDX_W-1:0] lvl_pos;
   logic                             soft_req;

   assign soft_req   = req.data_bits[sndtmr_pkg::BIT_SOFT];
   assign soft_bit   = sndtmr_pkg::PEND_W'(1) << sndtmr_pkg::BIT_SOFT;
   assign sample_bit = sndtmr_pkg::PEND_W'(1) << sndtmr_pkg::BIT_SAMPLE;
   assign wrap_bits  = sndtmr_pkg::PEND_W'(timer_wrap) << sndtmr_pkg::BIT_TIMER0;

   always_comb begin
      sound_nx = sound_ff;
      host_nx  = host_ff;
      unique case (sndtmr_pkg::cmd_type'(req.cmd))
         sndtmr_pkg::CMD_TICK: begin
            sound_nx = sound_ff | sample_bit | wrap_bits;
            host_nx  = host_ff | wrap_bits;
         end
         sndtmr_pkg::CMD_SOUND_SET: begin
            if (soft_req) sound_nx = sound_ff | soft_bit;
         end
         sndtmr_pkg::CMD_SOUND_CLR: sound_nx = sound_ff & ~req.data_bits;
         sndtmr_pkg::CMD_HOST_SET: begin
            if (soft_req) host_nx = host_ff | soft_bit;
         end
         sndtmr_pkg::CMD_HOST_CLR: host_nx = host_ff & ~req.data_bits;
         default: ;
      endcase
   end

   assign sound_in = advance ? sound_nx : sound_ff;
   assign host_in  = advance ? host_nx : host_ff;
   assign active   = sound_nx & cfg.sound_en;

   always_comb begin
      lvl_pos = '0;
      for (int i = sndtmr_pkg::PEND_W - 1; i >= 0; i--) begin
         if (active[i]) begin
            if (i >= sndtmr_pkg::LVL_MASK_W - 1) begin
               lvl_pos = sndtmr_pkg::LVL_IDX_W'(sndtmr_pkg::LVL_MASK_W - 1);
            end else begin
               lvl_pos = sndtmr_pkg::LVL_IDX_W'(i);
            end
         end
      end
      level = '0;
      if (|active) begin
         level = {cfg.level2[lvl_pos], cfg.level1[lvl_pos], cfg.level0[lvl_pos]};
      end
   end

   always_comb begin
      rsp_next.sound_cpu_active  = active;
      rsp_next.sound_cpu_level   = level;
      rsp_next.host_irq          = |(host_nx & cfg.host_en);
      rsp_next.sound_cpu_pending = sound_nx;
      rsp_next.host_pending      = host_nx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sound_ff <= '0;
         host_ff  <= '0;
      end else begin
         sound_ff <= sound_in;
         host_ff  <= host_in;
      end
   end

endmodule

// ----- src/sndtmr_checker.sv -----
// Port-level checks for the sound chip timer and interrupt core, bound to its top.
// Depends on sndtmr_pkg and sound_chip_timers_and_interrupts_core.
module sndtmr_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input sndtmr_pkg::rsp_type  rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   a_active_subset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.sound_cpu_active & ~rsp_data.sound_cpu_pending) == '0)
      else $error("active bit without pending bit");

   a_level_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.sound_cpu_active == '0) |-> rsp_data.sound_cpu_level == '0)
      else $error("nonzero level with no active source");

   a_host_irq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.host_irq |-> rsp_data.host_pending != '0)
      else $error("host irq with nothing pending");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item right after reset");

endmodule

bind sound_chip_timers_and_interrupts_core sndtmr_checker u_sndtmr_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
